// ===== design/ats_pkg.sv =====
// Shared types, constants and the arctangent table of the tilt angle smoother.
package ats_pkg;

	localparam int IN_W        = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int ANG_W       = 17;
	localparam int DIFF_W      = 17;
	localparam int PROD_W      = 33;
	localparam int VEC_W       = 36;
	localparam int RAD_W       = 34;
	localparam int RMAG_W      = 33;
	localparam int TBL_IDX_W   = 5;
	localparam int TBL_LEN     = 24;
	localparam int DEGP_W      = 50;
	localparam int DEG_N_W     = 19;
	localparam int RECIP_P_W   = 41;
	localparam int QUOT_W      = 16;
	localparam int SUM_W       = 20;

	localparam int CORDIC_STEPS_DEF = 16;

	// Q30 radians to 1/256 degree: r * 73344 / (5 * 2^30).
	localparam int FRAC_SH     = 30;
	localparam logic [16:0] DEG_MUL   = 17'd73344;
	// floor(n / 5) as (n * RECIP_M) >> RECIP_SH, exact for n below 2^22.
	localparam logic [21:0] RECIP_M   = 22'd3355444;
	localparam int RECIP_SH    = 24;

	localparam logic [QUOT_W-1:0] ANGLE_MAX = 16'd46080;
	localparam logic signed [RAD_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

	localparam logic [CFG_W-1:0] SCALE_RST = 16'd16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_BIAS  = 2'd0,
		CFG_Z_BIAS  = 2'd1,
		CFG_X_SCALE = 2'd2,
		CFG_Z_SCALE = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PRE,
		ST_ITER,
		ST_CONV,
		ST_DIV,
		ST_SMOOTH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                 load;
		logic                 mul;
		logic                 pre;
		logic                 iter;
		logic                 conv;
		logic                 div;
		logic                 smooth;
		logic                 commit;
		logic [TBL_IDX_W-1:0] step;
	} ats_cmd_t;

	function automatic logic [29:0] atan_q30(input logic [TBL_IDX_W-1:0] idx);
		logic [29:0] v;
		unique case (idx)
			5'd0:    v = 30'h3243F6A8;
			5'd1:    v = 30'h1DAC6705;
			5'd2:    v = 30'h0FADBAFC;
			5'd3:    v = 30'h07F56EA6;
			5'd4:    v = 30'h03FEAB76;
			5'd5:    v = 30'h01FFD55B;
			5'd6:    v = 30'h00FFFAAA;
			5'd7:    v = 30'h007FFF55;
			5'd8:    v = 30'h003FFFEA;
			5'd9:    v = 30'h001FFFFD;
			5'd10:   v = 30'h000FFFFF;
			5'd11:   v = 30'h0007FFFF;
			5'd12:   v = 30'h0003FFFF;
			5'd13:   v = 30'h0001FFFF;
			5'd14:   v = 30'h0000FFFF;
			5'd15:   v = 30'h00007FFF;
			5'd16:   v = 30'h00003FFF;
			5'd17:   v = 30'h00001FFF;
			5'd18:   v = 30'h00000FFF;
			5'd19:   v = 30'h000007FF;
			5'd20:   v = 30'h000003FF;
			5'd21:   v = 30'h000001FF;
			5'd22:   v = 30'h000000FF;
			5'd23:   v = 30'h0000007F;
			default: v = 30'h0;
		endcase
		return v;
	endfunction

endpackage

// ===== design/ats_if.sv =====
// Valid/ready channel interfaces for the sample input and the angle output.
interface ats_sample_if;
	import ats_pkg::*;
	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] accel_x_raw;
	logic signed [IN_W-1:0] accel_z_raw;

	modport source(output valid, output accel_x_raw, output accel_z_raw, input ready);
	modport sink(input valid, input accel_x_raw, input accel_z_raw, output ready);
endinterface

interface ats_angle_if;
	import ats_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [ANG_W-1:0] tilt_angle;

	modport source(output valid, output tilt_angle, input ready);
	modport sink(input valid, input tilt_angle, output ready);
endinterface

// ===== design/ats_datapath.sv =====
// Datapath: bias removal, cross products, CORDIC vectoring, degree scaling, smoothing.
module ats_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ats_pkg::ats_cmd_t                 cmd,
	input  logic signed [ats_pkg::IN_W-1:0]   accel_x_raw,
	input  logic signed [ats_pkg::IN_W-1:0]   accel_z_raw,
	input  logic                              cfg_we,
	input  logic [ats_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [ats_pkg::CFG_W-1:0]         cfg_wdata,
	output logic signed [ats_pkg::ANG_W-1:0]  tilt_angle
);
	import ats_pkg::*;

	logic signed [IN_W-1:0]   x_bias_q, z_bias_q;
	logic [CFG_W-1:0]         x_scale_q, z_scale_q;

	logic signed [DIFF_W-1:0] dx_q, dz_q;
	logic signed [PROD_W-1:0] yv_q, xv_q;
	logic signed [VEC_W-1:0]  x_q, y_q;
	logic signed [RAD_W-1:0]  r_q;
	logic                     zero_q;
	logic                     neg_q;
	logic [DEG_N_W-1:0]       deg_n_q;
	logic [QUOT_W-1:0]        quot_q;
	logic signed [ANG_W-1:0]  s_q;
	logic signed [ANG_W-1:0]  smoothed_q;

	logic signed [DIFF_W-1:0]   dx_d, dz_d;
	logic signed [2*DIFF_W-1:0] yv_full, xv_full;
	logic signed [VEC_W-1:0]    xv_ext, yv_ext, xs, ys;
	logic signed [RAD_W-1:0]    atan_v;
	logic [RMAG_W-1:0]          rmag;
	logic [DEGP_W-1:0]          deg_p;
	logic [RECIP_P_W-1:0]       recip_p;
	logic [QUOT_W-1:0]          amag;
	logic signed [ANG_W-1:0]    a_new;
	logic signed [SUM_W-1:0]    sum, adj, s_full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_bias_q  <= '0;
			z_bias_q  <= '0;
			x_scale_q <= SCALE_RST;
			z_scale_q <= SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_X_BIAS:  x_bias_q  <= cfg_wdata;
				CFG_Z_BIAS:  z_bias_q  <= cfg_wdata;
				CFG_X_SCALE: x_scale_q <= cfg_wdata;
				CFG_Z_SCALE: z_scale_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign dx_d    = DIFF_W'(accel_x_raw) - DIFF_W'(x_bias_q);
	assign dz_d    = DIFF_W'(accel_z_raw) - DIFF_W'(z_bias_q);
	assign yv_full = dx_q * $signed({1'b0, z_scale_q});
	assign xv_full = dz_q * $signed({1'b0, x_scale_q});

	assign xv_ext = VEC_W'(xv_q);
	assign yv_ext = VEC_W'(yv_q);
	assign xs     = x_q >>> cmd.step;
	assign ys     = y_q >>> cmd.step;
	assign atan_v = $signed(RAD_W'(atan_q30(cmd.step)));

	assign rmag    = zero_q ? '0 : (r_q[RAD_W-1] ? RMAG_W'(-r_q) : RMAG_W'(r_q));
	assign deg_p   = DEGP_W'(rmag) * DEGP_W'(DEG_MUL);
	assign recip_p = RECIP_P_W'(deg_n_q) * RECIP_P_W'(RECIP_M);

	// Saturate, restore the sign, then (3*old + new)/4 truncated toward zero.
	assign amag   = (quot_q > ANGLE_MAX) ? ANGLE_MAX : quot_q;
	assign a_new  = neg_q ? -$signed({1'b0, amag}) : $signed({1'b0, amag});
	assign sum    = (SUM_W'(smoothed_q) <<< 1) + SUM_W'(smoothed_q) + SUM_W'(a_new);
	assign adj    = sum + (sum[SUM_W-1] ? SUM_W'(3) : SUM_W'(0));
	assign s_full = adj >>> 2;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_q <= dx_d;
			dz_q <= dz_d;
		end
		if (cmd.mul) begin
			yv_q <= yv_full[PROD_W-1:0];
			xv_q <= xv_full[PROD_W-1:0];
		end
		if (cmd.pre) begin
			zero_q <= (xv_q == '0) && (yv_q == '0);
			// A quarter-turn pre-rotation brings the vector into the right half plane.
			if (xv_q[PROD_W-1]) begin
				if (!yv_q[PROD_W-1]) begin
					x_q <= yv_ext;
					y_q <= -xv_ext;
					r_q <= HALF_PI_Q30;
				end else begin
					x_q <= -yv_ext;
					y_q <= xv_ext;
					r_q <= -HALF_PI_Q30;
				end
			end else begin
				x_q <= xv_ext;
				y_q <= yv_ext;
				r_q <= '0;
			end
		end
		if (cmd.iter) begin
			if (!y_q[VEC_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				r_q <= r_q + atan_v;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				r_q <= r_q - atan_v;
			end
		end
		if (cmd.conv) begin
			neg_q   <= r_q[RAD_W-1] && !zero_q;
			deg_n_q <= deg_p[FRAC_SH+DEG_N_W-1:FRAC_SH];
		end
		if (cmd.div) begin
			quot_q <= recip_p[RECIP_SH+QUOT_W-1:RECIP_SH];
		end
		if (cmd.smooth) begin
			s_q <= s_full[ANG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= '0;
		end else if (cmd.commit) begin
			smoothed_q <= s_q;
		end
	end

	assign tilt_angle = smoothed_q;

endmodule

// ===== design/ats_ctrl.sv =====
// Controller: sequences one sample through the datapath and owns the handshakes.
module ats_ctrl #(
	parameter int CORDIC_STEPS = ats_pkg::CORDIC_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ats_pkg::ats_cmd_t cmd
);
	import ats_pkg::*;

	localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              in_fire;
	logic              out_fire;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_fire  = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.step = TBL_IDX_W'(step_q);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_PRE;
			end
			ST_PRE: begin
				cmd.pre = 1'b1;
				state_d = ST_ITER;
			end
			ST_ITER: begin
				cmd.iter = 1'b1;
				if (step_q == STEP_LAST) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.conv = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				state_d = ST_SMOOTH;
			end
			ST_SMOOTH: begin
				cmd.smooth = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.pre) begin
				step_q <= '0;
			end else if (cmd.iter) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_fire_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_MUL)
		else $error("accepted sample did not start the multiply step");

	a_iter_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER && step_q == STEP_LAST) |=> state_q == ST_CONV)
		else $error("CORDIC did not stop after the last step");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result overwritten before its transfer");

endmodule

// ===== design/accel_tilt_angle_smoother_unit.sv =====
// Top level of the accelerometer tilt angle smoother.
//
// Usage: one X/Z raw accelerometer pair is taken per transfer on the sample channel.
// The block removes the per-axis bias, forms atan2(x*z_scale, z*x_scale) with an
// iterative CORDIC, converts to 1/256 degree, saturates to +-180 degrees and
// returns the smoothed angle (3*old + new)/4 as one transfer on the result channel.
// The four registers are written through cfg_we/cfg_idx/cfg_wdata and should only
// change while no sample is in flight.
//
// After the sample transfer, the multiply, pre-rotation, CORDIC iteration, conversion,
// division and smoothing states follow before the result is committed. The one shared
// CORDIC add/shift unit handles a single sample at a time, so no new sample is taken
// before then. The result sits in an output register, so the next sample is taken
// while the previous result still waits; if the receiver stalls, that next sample is
// held at its final step until the output register is free.
//
// Reset clears the smoothed angle to zero, the biases to zero and both scales to
// 16384, and leaves both channels empty.
module accel_tilt_angle_smoother_unit #(
	parameter int CORDIC_STEPS = ats_pkg::CORDIC_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ats_sample_if.sink                    sample,
	ats_angle_if.source                   result,
	input  logic                          cfg_we,
	input  logic [ats_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ats_pkg::CFG_W-1:0]     cfg_wdata
);
	import ats_pkg::*;

	// Command bundle from the sequencer to the arithmetic.
	ats_cmd_t cmd;

	ats_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.cmd      (cmd)
	);

	// The smoothed angle register doubles as the output data; it only changes
	// when a new result is committed, which never happens while one is pending.
	ats_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.accel_x_raw(sample.accel_x_raw),
		.accel_z_raw(sample.accel_z_raw),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.tilt_angle (result.tilt_angle)
	);

endmodule

// ===== dv/ats_tilt_checker.sv =====
// Checker for the tilt angle smoother: predicts each smoothed angle and compares results.
`timescale 1ns / 1ps

module ats_tilt_checker #(
	parameter int STEPS = ats_pkg::CORDIC_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ats_sample_if                         smp,
	ats_angle_if                          res,
	input  logic                          cfg_we,
	input  logic [ats_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ats_pkg::CFG_W-1:0]     cfg_wdata,
	output int                            fail_count,
	output int                            pending
);
	import ats_pkg::*;

	localparam longint HALF_PI_RAD = 64'sd1686629713;
	localparam longint SAT_LIMIT   = 64'sd46080;
	localparam longint DEG_DIVISOR = 64'sd5368709120;

	// Arctangent of 2^-k in Q30 radians, truncated.
	longint atan_tab [0:23] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
		64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
		64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
		64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	logic signed [CFG_W-1:0] x_bias_q, z_bias_q;
	logic        [CFG_W-1:0] x_scale_q, z_scale_q;
	longint                  smooth_angle;
	logic signed [ANG_W-1:0] pending_angles [$];

	// New angle in 1/256 degree for the vector (xv, yv), saturated to +-180 degrees.
	function automatic longint cordic_tilt_deg(input longint yv, input longint xv);
		longint vx, vy, ang, sx, sy, tmp, deg;
		int     k;
		if (yv == 0 && xv == 0)
			return 0;
		vx = xv;
		vy = yv;
		ang = 0;
		// A quarter turn brings the left half plane into reach of the iterations.
		if (vx < 0) begin
			tmp = vx;
			if (vy >= 0) begin
				vx = vy;
				vy = -tmp;
				ang = HALF_PI_RAD;
			end else begin
				vx = -vy;
				vy = tmp;
				ang = -HALF_PI_RAD;
			end
		end
		for (k = 0; k < STEPS && k < 24; k++) begin
			sx = vx >>> k;
			sy = vy >>> k;
			if (vy >= 0) begin
				vx = vx + sy;
				vy = vy - sx;
				ang = ang + atan_tab[k];
			end else begin
				vx = vx - sy;
				vy = vy + sx;
				ang = ang - atan_tab[k];
			end
		end
		deg = (ang * 64'sd73344) / DEG_DIVISOR;
		if (deg > SAT_LIMIT)
			deg = SAT_LIMIT;
		if (deg < -SAT_LIMIT)
			deg = -SAT_LIMIT;
		return deg;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic signed [ANG_W-1:0] want;
		longint                  dx, dz, fresh;
		if (!arst_n) begin
			x_bias_q     = '0;
			z_bias_q     = '0;
			x_scale_q    = SCALE_RST;
			z_scale_q    = SCALE_RST;
			smooth_angle = 0;
			pending_angles.delete();
			pending      = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_idx))
					CFG_X_BIAS:  x_bias_q  = cfg_wdata;
					CFG_Z_BIAS:  z_bias_q  = cfg_wdata;
					CFG_X_SCALE: x_scale_q = cfg_wdata;
					CFG_Z_SCALE: z_scale_q = cfg_wdata;
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				if (pending_angles.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected tilt_angle transfer: expected none, actual %0d",
						$time, res.tilt_angle);
				end else begin
					want = pending_angles.pop_front();
					if (res.tilt_angle !== want) begin
						fail_count++;
						$display("%0t: tilt_angle mismatch: expected %0d, actual %0d",
							$time, want, res.tilt_angle);
					end
				end
			end
			if (smp.valid && smp.ready) begin
				dx = longint'(smp.accel_x_raw) - longint'(x_bias_q);
				dz = longint'(smp.accel_z_raw) - longint'(z_bias_q);
				// atan2(x/Fx, z/Fz) taken as atan2(x*Fz, z*Fx).
				fresh = cordic_tilt_deg(dx * longint'(z_scale_q), dz * longint'(x_scale_q));
				smooth_angle = (3 * smooth_angle + fresh) / 4;
				pending_angles.push_back(smooth_angle[ANG_W-1:0]);
			end
			pending = pending_angles.size();
		end
	end

endmodule

// ===== dv/tb_accel_tilt_angle_smoother_unit.sv =====
// Testbench top for the tilt angle smoother: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module tb_accel_tilt_angle_smoother_unit;
	import ats_pkg::*;

	// The default CORDIC depth is used by both the block and the checker.
	localparam int STEPS = CORDIC_STEPS_DEF;
	// SETTLE adds a margin to the CORDIC depth for letting the block settle.
	localparam int SETTLE = STEPS + 15;
	// Generous cycle budget for a couple of thousand samples, taken several times over.
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASES = 9;
	localparam int ITEMS_PER_PHASE = 206;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_wdata;
	int               fail_count;
	int               pending;
	int               cycles = 0;
	// Percent of cycles in which the sender holds off and the receiver stalls.
	int               snd_idle = 37;
	int               rcv_idle = 51;
	// Current biases, so that random samples can land on or near them.
	logic [CFG_W-1:0] cur_xb = '0;
	logic [CFG_W-1:0] cur_zb = '0;

	ats_sample_if sample_ch ();
	ats_angle_if  result_ch ();

	accel_tilt_angle_smoother_unit #(
		.CORDIC_STEPS(STEPS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	ats_tilt_checker #(
		.STEPS(STEPS)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp       (sample_ch),
		.res       (result_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver stalls at random, at whatever rate the current stage asks for.
	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= rcv_idle);
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("accel_tilt_angle_smoother_unit verification failed");
			$finish;
		end
	end

	// One sample transfer. Valid is left high afterwards, so that a sample that follows
	// with no gap keeps valid up without a low glitch in the same time step.
	task automatic send_sample(input logic [IN_W-1:0] x, input logic [IN_W-1:0] z);
		while ($urandom_range(99) < snd_idle) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid       <= 1'b1;
		sample_ch.accel_x_raw <= x;
		sample_ch.accel_z_raw <= z;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
	endtask

	// Stop sending and wait until every predicted angle has come back. The extra edge
	// makes sure the checker has already counted a transfer taken at the last edge.
	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes all four registers on back-to-back cycles; only called with the block idle.
	task automatic set_regs(input logic [CFG_W-1:0] xb, input logic [CFG_W-1:0] zb,
		input logic [CFG_W-1:0] xs, input logic [CFG_W-1:0] zs);
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_X_BIAS;
		cfg_wdata <= xb;
		@(posedge clk);
		cfg_idx   <= CFG_Z_BIAS;
		cfg_wdata <= zb;
		@(posedge clk);
		cfg_idx   <= CFG_X_SCALE;
		cfg_wdata <= xs;
		@(posedge clk);
		cfg_idx   <= CFG_Z_SCALE;
		cfg_wdata <= zs;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_xb = xb;
		cur_zb = zb;
	endtask

	function automatic logic [IN_W-1:0] edge_value();
		case ($urandom_range(4))
			0:       return 16'h8000;
			1:       return 16'hFFFF;
			2:       return 16'h0000;
			3:       return 16'h0001;
			default: return 16'h7FFF;
		endcase
	endfunction

	// Random sample. Besides full-range values it often hits an axis exactly (raw equal
	// to the bias), the zero vector, small vectors near the origin and the range limits.
	task automatic send_random();
		logic [IN_W-1:0] x, z;
		case ($urandom_range(9))
			4: begin
				x = cur_xb;
				z = IN_W'($urandom);
			end
			5: begin
				x = IN_W'($urandom);
				z = cur_zb;
			end
			6: begin
				x = cur_xb;
				z = cur_zb;
			end
			7: begin
				x = IN_W'(cur_xb + $urandom_range(600) - 300);
				z = IN_W'(cur_zb + $urandom_range(600) - 300);
			end
			8, 9: begin
				x = edge_value();
				z = edge_value();
			end
			default: begin
				x = IN_W'($urandom);
				z = IN_W'($urandom);
			end
		endcase
		send_sample(x, z);
	endtask

	initial begin : stimulus
		int ph, n;
		sample_ch.valid       <= 1'b0;
		sample_ch.accel_x_raw <= '0;
		sample_ch.accel_z_raw <= '0;
		cfg_we    <= 1'b0;
		cfg_idx   <= CFG_X_BIAS;
		cfg_wdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed samples with the registers at their reset values.
		send_sample(16'd0, 16'd0);          // zero vector gives a zero angle
		send_sample(16'd0, 16'd16384);      // level
		send_sample(16'd16384, 16'd0);      // straight up, +90 degrees
		send_sample(-16'sd16384, 16'd0);    // -90 degrees
		send_sample(16'd0, -16'sd16384);    // negative Z with X zero: +180, saturated
		send_sample(16'd1, 16'h8000);       // just short of +180
		send_sample(16'hFFFF, 16'h8000);    // just short of -180
		send_sample(16'h8000, 16'h8000);
		send_sample(16'h7FFF, 16'h7FFF);
		send_sample(16'h7FFF, 16'h8000);
		send_sample(16'h8000, 16'h7FFF);
		send_sample(16'h5555, 16'hAAAA);
		send_sample(16'hAAAA, 16'h5555);
		send_sample(16'h8000, 16'd0);
		send_sample(16'h7FFF, 16'd0);
		send_sample(16'd0, 16'h7FFF);
		send_sample(16'hFFFF, 16'hFFFF);
		send_sample(16'd1, 16'd1);
		drain();

		// A zero X scale leaves only the X product, so the angle goes to +-90 degrees,
		// or to zero when the X difference is zero as well.
		set_regs(16'd0, 16'd0, 16'd0, 16'd16384);
		send_sample(16'd100, 16'd0);
		send_sample(16'd5, -16'sd7);
		send_sample(16'd0, 16'd5);

		// Random phases, each under its own register setting. The first three run with
		// the sender idling less than the receiver, the next three the other way round,
		// and the last three with no idling at all.
		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph / 3)
				0: begin
					snd_idle = 37;
					rcv_idle = 51;
				end
				1: begin
					snd_idle = 51;
					rcv_idle = 37;
				end
				default: begin
					snd_idle = 0;
					rcv_idle = 0;
				end
			endcase
			case (ph)
				0: set_regs(16'd0, 16'd0, 16'd16384, 16'd16384);
				1: set_regs(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
				2: set_regs(16'h7FFF, 16'h8000, 16'd1, 16'd1);
				3: set_regs(CFG_W'($urandom), CFG_W'($urandom), 16'd0,
					CFG_W'($urandom_range(65535, 1)));
				4: set_regs(CFG_W'($urandom), CFG_W'($urandom),
					CFG_W'($urandom_range(65535, 1)), 16'd0);
				5: set_regs(16'h8000, 16'h8000, 16'd1, 16'hFFFF);
				default: begin
					// Realistic setting: small offsets and arbitrary nonzero scales.
					set_regs(CFG_W'($urandom_range(4000) - 2000),
						CFG_W'($urandom_range(4000) - 2000),
						CFG_W'($urandom_range(65535, 1)), CFG_W'($urandom_range(65535, 1)));
				end
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				send_random();
		end
		drain();

		if (fail_count == 0) begin
			$display("accel_tilt_angle_smoother_unit verification clean");
		end else begin
			$display("accel_tilt_angle_smoother_unit verification failed");
		end
		$finish;
	end

endmodule
